>>> rtl/boxf_pkg.sv
// ============================================================================
// boxf_pkg
// Shared types and constants of the 3x3 edge-clipped box filter: payload
// structs of both queues, the command passed from front to back, register
// indexes and the reciprocal table used for the mean.
// ============================================================================
`default_nettype none

package boxf_pkg;

    // Field widths fixed by the interface.
    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Queue depths (power of two).
    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 8;
    localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

    // Window sum, divisor and reciprocal arithmetic.
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_W     = 19;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } reg_index_t;

    // One input transaction.
    typedef struct packed {
        logic             operation;
        logic [PIX_W-1:0] pixel_value;
    } item_t;

    // One result transaction.
    typedef struct packed {
        logic [PIX_W-1:0] mean_value;
        logic             frame_last;
    } result_t;

    // Classified command from the front part to the back part.
    typedef struct packed {
        logic             wr_en;     // pixel lies inside the frame
        logic [1:0]       bank;      // input row modulo four
        logic             has_out;   // this command releases a result
        logic             top_ok;    // row above the output pixel is inside
        logic             bot_ok;    // row below the output pixel is inside
        logic             left_ok;   // column left of the output pixel is inside
        logic             right_ok;  // column right of the output pixel is inside
        logic             last;      // result is the final pixel of the frame
        logic [PIX_W-1:0] pix;       // pixel value, zero for a drain
    } ctrl_t;

    // Reciprocal of the in-image tap count, scaled by 2^RECIP_SHIFT and
    // rounded up. Exact truncated quotient for every sum below 2^SUM_W.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        unique case (cnt)
            4'd1:    m = 19'd262144;
            4'd2:    m = 19'd131072;
            4'd3:    m = 19'd87382;
            4'd4:    m = 19'd65536;
            4'd6:    m = 19'd43691;
            4'd9:    m = 19'd29128;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

>>> rtl/box_filter_3x3_edge_clipped.sv
// ============================================================================
// box_filter_3x3_edge_clipped
// 3x3 mean filter over a raster stream of 8-bit grey pixels with the
// neighborhood clipped at the image borders.
//
//   channel   direction  handshake                  payload
//   cfg       in         cfg_valid / cfg_ready      cfg_index, cfg_data
//   item      in         push / full                item (operation, pixel_value)
//   result    out        pop / empty                result (mean_value, frame_last)
//
// One transaction per clock is sustained while results are popped; a result
// becomes visible once its releasing transaction has passed the command
// queue, the registered line-store read, two arithmetic stages and the result
// queue. full rises when the four-entry command queue fills; the back part
// issues a command only while the eight-entry result queue has room for all
// results in flight. Reset needs no clearing pass: every line-store value that
// enters a sum is written earlier in the same frame. cfg_ready is always high.
// ============================================================================
`default_nettype none

module box_filter_3x3_edge_clipped #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [boxf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [boxf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              push,
    output logic                              full,
    input  boxf_pkg::item_t                   item,
    input  logic                              pop,
    output logic                              empty,
    output boxf_pkg::result_t                 result
);

    import boxf_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int CTRL_W = $bits(ctrl_t);
    localparam int CMD_W  = CTRL_W + CW;
    localparam int RES_W  = $bits(result_t);

    logic              cmd_push;
    ctrl_t             cmd_ctrl;
    logic [CW-1:0]     cmd_col;
    logic [CMD_W-1:0]  cmd_wdata;
    logic [CMD_W-1:0]  cmd_rdata;
    logic              cmd_empty;
    logic              cmd_pop;
    ctrl_t             cmd_ctrl_q;
    logic [CW-1:0]     cmd_col_q;
    logic              res_push;
    result_t           res_data;
    logic [RES_W-1:0]  res_rdata;
    logic [OCNT_W-1:0] out_count;

    assign cfg_ready  = 1'b1;
    assign cmd_wdata  = {cmd_col, cmd_ctrl};
    assign cmd_ctrl_q = ctrl_t'(cmd_rdata[CTRL_W-1:0]);
    assign cmd_col_q  = cmd_rdata[CMD_W-1:CTRL_W];
    assign result     = result_t'(res_rdata);

    // Front part: positions, frame size and classification.
    boxf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_push  (cmd_push),
        .cmd_ctrl  (cmd_ctrl),
        .cmd_col   (cmd_col)
    );

    // Command queue between the two parts.
    boxf_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_wdata),
        .full    (full),
        .pop     (cmd_pop),
        .rd_data (cmd_rdata),
        .empty   (cmd_empty),
        .count   ()
    );

    // Back part: line store, window and mean.
    boxf_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd_ctrl  (cmd_ctrl_q),
        .cmd_col   (cmd_col_q),
        .cmd_pop   (cmd_pop),
        .out_count (out_count),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    // Result queue toward the consumer.
    boxf_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_data),
        .full    (),
        .pop     (pop),
        .rd_data (res_rdata),
        .empty   (empty),
        .count   (out_count)
    );

endmodule

`default_nettype wire

>>> rtl/boxf_fifo.sv
// ============================================================================
// boxf_fifo
// Small flip-flop queue used between the front and back parts and for the
// results. DEPTH must be a power of two.
// ============================================================================
`default_nettype none

module boxf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             wr_data,
    output logic                         full,
    input  logic                         pop,
    output logic [WIDTH-1:0]             rd_data,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    // Handshake qualification and status.
    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNTW'(1);
            2'b01:   count_next = count_reg - CNTW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage; no reset needed on payload.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/boxf_front.sv
// ============================================================================
// boxf_front
// Front part: holds the frame size registers, tracks input and output raster
// positions and turns every accepted transaction into a classified command.
// ============================================================================
`default_nettype none

module boxf_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr,
    input  logic [boxf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [boxf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              push,
    input  logic                              full,
    input  boxf_pkg::item_t                   item,
    output logic                              cmd_push,
    output boxf_pkg::ctrl_t                   cmd_ctrl,
    output logic [$clog2(MAX_WIDTH)-1:0]      cmd_col
);

    import boxf_pkg::*;

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int IRW   = $clog2(MAX_HEIGHT + 3);
    localparam int ORW   = $clog2(MAX_HEIGHT);
    localparam int LW    = $clog2(MAX_WIDTH + 2);
    localparam int RST_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int RST_H = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

    logic [WW-1:0]  width_reg, width_next;
    logic [HW-1:0]  height_reg, height_next;
    logic [CW-1:0]  in_col_reg, in_col_next;
    logic [IRW-1:0] in_row_reg, in_row_next;
    logic [LW-1:0]  lead_reg, lead_next;
    logic [CW-1:0]  out_col_reg, out_col_next;
    logic [ORW-1:0] out_row_reg, out_row_next;

    logic          acc;
    logic          has_out;
    logic          last;
    logic [WW-1:0] width_cfg;
    logic [HW-1:0] height_cfg;

    // A zero size acts as one; sizes beyond the maximum saturate.
    always_comb
    begin
        if (cfg_data == '0)
            width_cfg = WW'(1);
        else if (32'(cfg_data) > MAX_WIDTH)
            width_cfg = WW'(MAX_WIDTH);
        else
            width_cfg = WW'(cfg_data);

        if (cfg_data == '0)
            height_cfg = HW'(1);
        else if (32'(cfg_data) > MAX_HEIGHT)
            height_cfg = HW'(MAX_HEIGHT);
        else
            height_cfg = HW'(cfg_data);
    end

    // Results start once width+1 transactions of the frame have arrived.
    always_comb
    begin
        acc     = push && !full;
        has_out = 32'(lead_reg) >= 32'(width_reg) + 32'd1;
        last    = has_out
                  && (32'(out_row_reg) + 32'd1 == 32'(height_reg))
                  && (32'(out_col_reg) + 32'd1 == 32'(width_reg));
    end

    // Command classification.
    always_comb
    begin
        cmd_push          = acc;
        cmd_col           = in_col_reg;
        cmd_ctrl.wr_en    = 32'(in_row_reg) < 32'(height_reg);
        cmd_ctrl.bank     = in_row_reg[1:0];
        cmd_ctrl.has_out  = has_out;
        cmd_ctrl.top_ok   = (out_row_reg != '0);
        cmd_ctrl.bot_ok   = 32'(out_row_reg) + 32'd1 < 32'(height_reg);
        cmd_ctrl.left_ok  = (out_col_reg != '0);
        cmd_ctrl.right_ok = 32'(out_col_reg) + 32'd1 < 32'(width_reg);
        cmd_ctrl.last     = last;
        cmd_ctrl.pix      = item.operation ? '0 : item.pixel_value;
    end

    // Position counters and configuration registers.
    always_comb
    begin
        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        lead_next    = lead_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        priority if (cfg_wr)
        begin
            if (cfg_index == REG_IMAGE_WIDTH)
                width_next = width_cfg;
            if (cfg_index == REG_IMAGE_HEIGHT)
                height_next = height_cfg;
            if (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                lead_next    = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
        end
        else if (acc)
        begin
            // Input position stops two rows past the frame.
            if (32'(in_row_reg) < 32'(height_reg) + 32'd2)
            begin
                if (32'(in_col_reg) + 32'd1 >= 32'(width_reg))
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + IRW'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + CW'(1);
                end
            end

            if (32'(lead_reg) < 32'(width_reg) + 32'd1)
                lead_next = lead_reg + LW'(1);

            if (has_out)
            begin
                if (32'(out_col_reg) + 32'd1 >= 32'(width_reg))
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ORW'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + CW'(1);
                end
            end

            // The final result of the frame restarts all positions.
            if (last)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                lead_next    = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WW'(RST_W);
            height_reg  <= HW'(RST_H);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            lead_reg    <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            lead_reg    <= lead_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

`ifndef SYNTH
    // The input column always stays inside the configured row.
    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        32'(in_col_reg) < 32'(width_reg))
        else $error("input column beyond image width");

    // A result is only released for a pixel inside the frame.
    a_out_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && has_out) |-> (32'(out_row_reg) < 32'(height_reg)))
        else $error("result released for a row outside the frame");

    // The final result restarts the frame on the next cycle.
    a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && last && !cfg_wr) |=>
            (in_row_reg == '0 && in_col_reg == '0 && lead_reg == '0
             && out_row_reg == '0 && out_col_reg == '0))
        else $error("frame did not restart after its final result");
`endif

endmodule

`default_nettype wire

>>> rtl/boxf_back.sv
// ============================================================================
// boxf_back
// Back part: line store of four row banks, 3x3 sliding window, masked sum
// and tap count, reciprocal multiply for the truncated mean.
// ============================================================================
`default_nettype none

module boxf_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  boxf_pkg::ctrl_t                   cmd_ctrl,
    input  logic [$clog2(MAX_WIDTH)-1:0]      cmd_col,
    output logic                              cmd_pop,
    input  logic [boxf_pkg::OCNT_W-1:0]       out_count,
    output logic                              res_push,
    output boxf_pkg::result_t                 res_data
);

    import boxf_pkg::*;

    localparam int PROD_W = SUM_W + RECIP_W;

    // Line store: one bank per row modulo four.
    logic [PIX_W-1:0] line_mem [4][MAX_WIDTH];
    logic [PIX_W-1:0] rd_reg [4];

    logic             s1_valid_reg;
    ctrl_t            s1_ctrl_reg;
    logic [PIX_W-1:0] col_a_reg [3];
    logic [PIX_W-1:0] col_b_reg [3];
    logic [PIX_W-1:0] new_col [3];
    logic [2:0]       row_ok;
    logic [2:0]       col_ok;
    logic [PIX_W+1:0] row_sum [3];
    logic [1:0]       rows_in;
    logic [1:0]       cols_in;
    logic [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0] cnt_next;

    logic             s2_valid_reg;
    logic [SUM_W-1:0] s2_sum_reg;
    logic [CNT_W-1:0] s2_cnt_reg;
    logic             s2_last_reg;

    logic [PROD_W-1:0] prod;
    logic              s3_valid_reg;
    logic [PIX_W-1:0]  s3_mean_reg;
    logic              s3_last_reg;

    logic [OCNT_W:0]   in_use;

    // Issue only when the result queue has room for everything in flight.
    always_comb
    begin
        in_use = (OCNT_W+1)'(out_count)
                 + (OCNT_W+1)'(s1_valid_reg && s1_ctrl_reg.has_out)
                 + (OCNT_W+1)'(s2_valid_reg)
                 + (OCNT_W+1)'(s3_valid_reg);
        cmd_pop = cmd_valid && (in_use < (OCNT_W+1)'(OUT_DEPTH));
    end

    // Write the current pixel and read the same column from every bank.
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            for (int b = 0; b < 4; b++)
            begin
                if (cmd_ctrl.wr_en && (cmd_ctrl.bank == 2'(b)))
                    line_mem[b][cmd_col] <= cmd_ctrl.pix;
                rd_reg[b] <= line_mem[b][cmd_col];
            end
        end
    end

    // New window column: two rows above from the store, bottom from the input.
    always_comb
    begin
        new_col[0] = rd_reg[s1_ctrl_reg.bank - 2'd2];
        new_col[1] = rd_reg[s1_ctrl_reg.bank - 2'd1];
        new_col[2] = s1_ctrl_reg.pix;
        row_ok     = {s1_ctrl_reg.bot_ok, 1'b1, s1_ctrl_reg.top_ok};
        col_ok     = {s1_ctrl_reg.right_ok, 1'b1, s1_ctrl_reg.left_ok};
    end

    // Sum of in-image taps and their count.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            row_sum[r] = ((row_ok[r] && col_ok[0]) ? (PIX_W+2)'(col_a_reg[r]) : '0)
                       + ((row_ok[r] && col_ok[1]) ? (PIX_W+2)'(col_b_reg[r]) : '0)
                       + ((row_ok[r] && col_ok[2]) ? (PIX_W+2)'(new_col[r]) : '0);
        end
        sum_next = SUM_W'(row_sum[0]) + SUM_W'(row_sum[1]) + SUM_W'(row_sum[2]);
        rows_in  = 2'd1 + 2'(s1_ctrl_reg.top_ok) + 2'(s1_ctrl_reg.bot_ok);
        cols_in  = 2'd1 + 2'(s1_ctrl_reg.left_ok) + 2'(s1_ctrl_reg.right_ok);
        cnt_next = CNT_W'(rows_in) * CNT_W'(cols_in);
    end

    // Divide by the tap count through its reciprocal.
    always_comb
    begin
        prod = PROD_W'(s2_sum_reg) * PROD_W'(recip(s2_cnt_reg));
    end

    always_comb
    begin
        res_push            = s3_valid_reg;
        res_data.mean_value = s3_mean_reg;
        res_data.frame_last = s3_last_reg;
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd_pop;
            s2_valid_reg <= s1_valid_reg && s1_ctrl_reg.has_out;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage payloads and the sliding window.
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
            s1_ctrl_reg <= cmd_ctrl;
        if (s1_valid_reg)
        begin
            col_a_reg   <= col_b_reg;
            col_b_reg   <= new_col;
            s2_sum_reg  <= sum_next;
            s2_cnt_reg  <= cnt_next;
            s2_last_reg <= s1_ctrl_reg.last;
        end
        if (s2_valid_reg)
        begin
            s3_mean_reg <= prod[RECIP_SHIFT +: PIX_W];
            s3_last_reg <= s2_last_reg;
        end
    end

`ifndef SYNTH
    // The credit check keeps the result queue from overflowing.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (32'(out_count) < OUT_DEPTH))
        else $error("result pushed into a full queue");

    // The tap count is always a valid divisor.
    a_cnt_legal: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_cnt_reg == 4'd1 || s2_cnt_reg == 4'd2 || s2_cnt_reg == 4'd3
                          || s2_cnt_reg == 4'd4 || s2_cnt_reg == 4'd6 || s2_cnt_reg == 4'd9))
        else $error("illegal tap count");

    // A result-bearing command in stage one passes stage two and reaches the mean register of stage three.
    a_result_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_ctrl_reg.has_out) |=> ##1 s3_valid_reg)
        else $error("result lost in the back pipeline");
`endif

endmodule

`default_nettype wire
